// File: hdl/cci_pkg.sv
// Package for the cross-correlation integrator: sizes, item codes, queue
// entry and state types, triangle address function.
// No dependencies.
`default_nettype none

package cci_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int SAMPLE_BITS  = 16;
	localparam int ELEM_W       = $clog2(MAX_ELEMENTS);
	localparam int NUM_W        = ELEM_W + 1;
	localparam int TRI_DEPTH    = MAX_ELEMENTS * (MAX_ELEMENTS + 1) / 2;
	localparam int ACC_AW       = $clog2(TRI_DEPTH);
	localparam int ACC_W        = 64;
	localparam int PROD_W       = 2 * SAMPLE_BITS;
	localparam int CQ_DEPTH     = 4;
	localparam int CQ_AW        = $clog2(CQ_DEPTH);

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef struct packed {
		func_t                          op;
		logic [ELEM_W-1:0]              element;
		logic signed [SAMPLE_BITS-1:0]  re;
		logic signed [SAMPLE_BITS-1:0]  im;
		logic [ACC_AW-1:0]              addr;
		logic                           ok;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} back_status_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_SETUP,
		B_RUN,
		B_DRAIN,
		B_RWAIT
	} back_state_t;

	// col*(col+1)/2 + row
	function automatic logic [ACC_AW-1:0] tri_index(
		input logic [ELEM_W-1:0] row,
		input logic [ELEM_W-1:0] col
	);
		logic [ACC_AW:0] prod;
		prod = (ACC_AW+1)'(col) * ((ACC_AW+1)'(col) + (ACC_AW+1)'(1));
		tri_index = ACC_AW'(prod >> 1) + ACC_AW'(row);
	endfunction

endpackage

`default_nettype wire

// File: hdl/cci_front.sv
// Front end: takes input transfers, classifies them and queues commands.
// Depends on cci_pkg.
`default_nettype none

module cci_front
	import cci_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [1:0]                    func,
	input  wire logic [ELEM_W-1:0]             element,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_re,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_im,
	input  wire logic [ELEM_W-1:0]             read_row,
	input  wire logic [ELEM_W-1:0]             read_col,
	input  wire logic [NUM_W-1:0]              num_elements,
	input  wire back_status_t                  status,
	output logic                               cmd_valid,
	output cmd_t                               cmd,
	input  wire logic                          cmd_pop
);

	cmd_t               q_q [CQ_DEPTH];
	logic [CQ_AW-1:0]   wp_q, rp_q;
	logic [CQ_AW:0]     cnt_q;
	logic [NUM_W-1:0]   n_act;
	cmd_t               c_new;
	logic               keep, accept, enq;

	assign n_act = (num_elements > NUM_W'(MAX_ELEMENTS)) ? NUM_W'(MAX_ELEMENTS) : num_elements;

	always_comb begin
		c_new.op      = func_t'(func);
		c_new.element = element;
		c_new.re      = sample_re;
		c_new.im      = sample_im;
		c_new.addr    = tri_index(read_row, read_col);
		c_new.ok      = (read_row <= read_col) && (NUM_W'(read_col) < n_act);
		unique case (func_t'(func))
			FUNC_SAMPLE: keep = NUM_W'(element) < n_act;
			FUNC_READ:   keep = 1'b1;
			FUNC_CLEAR:  keep = 1'b1;
			default:     keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == (CQ_AW+1)'(CQ_DEPTH)) || status.clearing;
	assign accept    = push && !full;
	assign enq       = accept && keep;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq)
			q_q[wp_q] <= c_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq)
				wp_q <= wp_q + CQ_AW'(1);
			if (cmd_pop && cmd_valid)
				rp_q <= rp_q + CQ_AW'(1);
			cnt_q <= cnt_q + (CQ_AW+1)'(enq) - (CQ_AW+1)'(cmd_pop && cmd_valid);
		end
	end

endmodule

`default_nettype wire

// File: hdl/cci_back.sv
// Back end: slice buffer, accumulator memory, multiply-accumulate pipeline,
// clearing sweep and result queue. Depends on cci_pkg.
`default_nettype none

module cci_back
	import cci_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	input  wire cmd_t  cmd,
	output logic       cmd_pop,
	output back_status_t status,
	output logic       empty,
	input  wire logic  pop,
	output logic signed [ACC_W-1:0] vis_re,
	output logic signed [ACC_W-1:0] vis_im,
	output logic       read_ok
);

	back_state_t state_q, state_d;

	logic [ACC_AW-1:0]              cnt_q;
	logic [ELEM_W-1:0]              x_q, e_q;
	logic signed [SAMPLE_BITS-1:0]  er_q, ei_q;
	logic [ACC_AW-1:0]              k_q;

	// memories
	logic [2*SAMPLE_BITS-1:0] slice_mem [MAX_ELEMENTS];
	logic [2*SAMPLE_BITS-1:0] slice_rd_q;
	logic [2*ACC_W-1:0]       acc_mem [TRI_DEPTH];
	logic [2*ACC_W-1:0]       acc_rd_q;
	logic [ACC_AW-1:0]        acc_raddr, acc_waddr;
	logic [2*ACC_W-1:0]       acc_wdata;
	logic                     acc_we, slice_we;

	// pipeline
	logic                     v_s1, v_s2;
	logic [ACC_AW-1:0]        k_s1, k_s2;
	logic signed [PROD_W-1:0] rr_s2, ii_s2, ir_s2, ri_s2;
	logic [2*ACC_W-1:0]       acc_s2;
	logic signed [PROD_W:0]   pr, pi;
	logic signed [SAMPLE_BITS-1:0] xr, xi;

	// result queue
	logic [2*ACC_W:0] oq_q [2];
	logic             owp_q, orp_q;
	logic [1:0]       ocnt_q;
	logic             opush;
	logic [2*ACC_W:0] odata;

	logic issue, clr_last;

	assign clr_last = cnt_q == ACC_AW'(TRI_DEPTH - 1);
	assign xr = slice_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign xi = slice_rd_q[SAMPLE_BITS-1:0];

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		issue     = 1'b0;
		slice_we  = 1'b0;
		opush     = 1'b0;
		odata     = '0;
		acc_raddr = (state_q == B_RUN) ? k_q : cmd.addr;
		unique case (state_q)
			B_CLEAR: if (clr_last) state_d = B_IDLE;
			B_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						FUNC_SAMPLE: begin
							cmd_pop = 1'b1;
							state_d = B_SETUP;
						end
						FUNC_READ: begin
							if (ocnt_q != 2'd2) begin
								cmd_pop = 1'b1;
								if (cmd.ok)
									state_d = B_RWAIT;
								else
									opush = 1'b1;
							end
						end
						FUNC_CLEAR: begin
							cmd_pop = 1'b1;
							state_d = B_CLEAR;
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			B_SETUP: begin
				slice_we = 1'b1;
				state_d  = B_RUN;
			end
			B_RUN: begin
				issue = 1'b1;
				if (x_q == e_q) state_d = B_DRAIN;
			end
			B_DRAIN: if (!v_s1 && !v_s2) state_d = B_IDLE;
			B_RWAIT: begin
				opush   = 1'b1;
				odata   = {acc_rd_q, 1'b1};
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign status.clearing = state_q == B_CLEAR;
	assign status.idle     = state_q == B_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR)
				cnt_q <= clr_last ? '0 : cnt_q + ACC_AW'(1);
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			e_q  <= cmd.element;
			er_q <= cmd.re;
			ei_q <= cmd.im;
		end
		if (state_q == B_SETUP) begin
			x_q <= '0;
			k_q <= tri_index('0, e_q);
		end else if (issue) begin
			x_q <= x_q + ELEM_W'(1);
			k_q <= k_q + ACC_AW'(1);
		end
		k_s1  <= k_q;
		k_s2  <= k_s1;
		rr_s2 <= xr * er_q;
		ii_s2 <= xi * ei_q;
		ir_s2 <= xi * er_q;
		ri_s2 <= xr * ei_q;
		acc_s2 <= acc_rd_q;
	end

	always_ff @(posedge clk) begin
		if (slice_we)
			slice_mem[e_q] <= {er_q, ei_q};
		slice_rd_q <= slice_mem[x_q];
	end

	assign pr = (PROD_W+1)'(rr_s2) + (PROD_W+1)'(ii_s2);
	assign pi = (PROD_W+1)'(ir_s2) - (PROD_W+1)'(ri_s2);

	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = k_s2;
		acc_wdata = {acc_s2[2*ACC_W-1:ACC_W] + ACC_W'(pr), acc_s2[ACC_W-1:0] + ACC_W'(pi)};
		if (state_q == B_CLEAR) begin
			acc_we    = 1'b1;
			acc_waddr = cnt_q;
			acc_wdata = '0;
		end else if (v_s2) begin
			acc_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_waddr] <= acc_wdata;
		acc_rd_q <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk) begin
		if (opush)
			oq_q[owp_q] <= odata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (opush)
				owp_q <= !owp_q;
			if (pop && !empty)
				orp_q <= !orp_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(pop && !empty);
		end
	end

	assign empty   = ocnt_q == '0;
	assign vis_re  = oq_q[orp_q][2*ACC_W:ACC_W+1];
	assign vis_im  = oq_q[orp_q][ACC_W:1];
	assign read_ok = oq_q[orp_q][0];

endmodule

`default_nettype wire

// File: hdl/cross_correlation_integrator.sv
// Top level of the cross-correlation integrator: configuration register,
// front end and back end. Depends on cci_pkg, cci_front, cci_back.
//
// A sample for element e holds the back end from the cycle that takes the
// command: it is stored in the slice buffer, then one accumulator update per
// stored element 0..e goes through the accumulator memory (separate read
// and write ports), then the pipeline drains. A valid read goes through the
// registered accumulator read and state B_RWAIT, an invalid one is answered
// in the cycle that takes it; a clear sweeps all 2080 accumulator rows at
// one per cycle after the cycle that takes it. After reset the same sweep
// runs with full held high; configuration writes are taken throughout.
// A four-entry command queue separates input transfers from the back end.
`default_nettype none

module cross_correlation_integrator
	import cci_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [1:0]                    func,
	input  wire logic [ELEM_W-1:0]             element,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_re,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_im,
	input  wire logic [ELEM_W-1:0]             read_row,
	input  wire logic [ELEM_W-1:0]             read_col,
	output logic                               empty,
	input  wire logic                          pop,
	output logic signed [ACC_W-1:0]            vis_re,
	output logic signed [ACC_W-1:0]            vis_im,
	output logic                               read_ok,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [NUM_W-1:0]              cfg_data
);

	logic [NUM_W-1:0] num_elements_q;
	logic             cmd_valid, cmd_pop;
	cmd_t             cmd;
	back_status_t     status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_elements_q <= NUM_W'(MAX_ELEMENTS);
		else if (cfg_valid && cfg_ready)
			num_elements_q <= cfg_data;
	end

	cci_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.element      (element),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.read_row     (read_row),
		.read_col     (read_col),
		.num_elements (num_elements_q),
		.status       (status),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	cci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.status    (status),
		.empty     (empty),
		.pop       (pop),
		.vis_re    (vis_re),
		.vis_im    (vis_im),
		.read_ok   (read_ok)
	);

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for cross_correlation_integrator: drives samples, visibility reads
// and clears through the queue ports and checks every visibility against its own
// integrator model held in a small scoreboard class. Depends on cci_pkg and the top level.
`default_nettype none

module testbench;
	import cci_pkg::*;

	localparam int IDLE_LIMIT  = 60000;
	localparam int SETTLE_WAIT = 11000;

	typedef struct {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
		logic                    ok;
	} visibility_t;

	class vis_scoreboard;
		logic signed [SAMPLE_BITS-1:0] slice_re[MAX_ELEMENTS];
		logic signed [SAMPLE_BITS-1:0] slice_im[MAX_ELEMENTS];
		logic [ACC_W-1:0]              sum_re[TRI_DEPTH];
		logic [ACC_W-1:0]              sum_im[TRI_DEPTH];
		int                            in_use;
		visibility_t                   pending_q[$];

		function new();
			foreach (sum_re[i]) begin
				sum_re[i] = '0;
				sum_im[i] = '0;
			end
			foreach (slice_re[i]) begin
				slice_re[i] = '0;
				slice_im[i] = '0;
			end
			in_use = MAX_ELEMENTS;
		endfunction

		function void set_count(int value);
			in_use = (value > MAX_ELEMENTS) ? MAX_ELEMENTS : value;
		endfunction

		function int pair_addr(int row, int col);
			return col * (col + 1) / 2 + row;
		endfunction

		function void note_item(logic [1:0] op, int elem, logic signed [SAMPLE_BITS-1:0] re,
				logic signed [SAMPLE_BITS-1:0] im, int row, int col);
			visibility_t v;
			longint pr, pi;
			int k;
			case (op)
				FUNC_SAMPLE: begin
					if (elem < in_use) begin
						slice_re[elem] = re;
						slice_im[elem] = im;
						for (int x = 0; x <= elem; x++) begin
							// s_x * conj(s_e)
							pr = longint'(slice_re[x]) * longint'(re)
								+ longint'(slice_im[x]) * longint'(im);
							pi = longint'(slice_im[x]) * longint'(re)
								- longint'(slice_re[x]) * longint'(im);
							k = pair_addr(x, elem);
							sum_re[k] = sum_re[k] + pr;
							sum_im[k] = sum_im[k] + pi;
						end
					end
				end
				FUNC_READ: begin
					if (row <= col && col < in_use) begin
						k = pair_addr(row, col);
						v.re = sum_re[k];
						v.im = sum_im[k];
						v.ok = 1'b1;
					end else begin
						v.re = '0;
						v.im = '0;
						v.ok = 1'b0;
					end
					pending_q.push_back(v);
				end
				FUNC_CLEAR: begin
					foreach (sum_re[i]) begin
						sum_re[i] = '0;
						sum_im[i] = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function string check(logic signed [ACC_W-1:0] re, logic signed [ACC_W-1:0] im,
				logic ok);
			visibility_t v;
			if (pending_q.size() == 0)
				return "visibility transfer with none outstanding";
			v = pending_q.pop_front();
			if (ok !== v.ok)
				return $sformatf("read_ok %0b, wanted %0b", ok, v.ok);
			if (re !== v.re)
				return $sformatf("vis_re %0d, wanted %0d", re, v.re);
			if (im !== v.im)
				return $sformatf("vis_im %0d, wanted %0d", im, v.im);
			return "";
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic [1:0]                    func;
	logic [ELEM_W-1:0]             element;
	logic signed [SAMPLE_BITS-1:0] sample_re;
	logic signed [SAMPLE_BITS-1:0] sample_im;
	logic [ELEM_W-1:0]             read_row;
	logic [ELEM_W-1:0]             read_col;
	logic                          empty;
	logic                          pop;
	logic signed [ACC_W-1:0]       vis_re;
	logic signed [ACC_W-1:0]       vis_im;
	logic                          read_ok;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [NUM_W-1:0]              cfg_data;

	vis_scoreboard sb = new();
	int    errors = 0;
	int    n_inputs = 0;
	int    n_reads = 0;
	int    n_settings = 0;
	int    idle_cycles = 0;
	int    pop_pct = 100;
	int    gap_max = 0;
	int    burst_left = 1;
	string msg;

	cross_correlation_integrator uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.element(element), .sample_re(sample_re), .sample_im(sample_im),
		.read_row(read_row), .read_col(read_col), .empty(empty), .pop(pop),
		.vis_re(vis_re), .vis_im(vis_im), .read_ok(read_ok),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report(string text);
		$display("MISMATCH at %0t: %s", $time, text);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				sb.note_item(func, element, sample_re, sample_im, read_row, read_col);
				n_inputs++;
			end
			if (pop && !empty) begin
				msg = sb.check(vis_re, vis_im, read_ok);
				if (msg != "")
					report(msg);
				n_reads++;
			end
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver stall pattern
	always @(posedge clk)
		pop <= arst_n && ($urandom_range(0, 99) < pop_pct);

	task automatic send(logic [1:0] op, int elem, int re, int im, int row, int col);
		push <= 1'b1;
		func <= op;
		element <= elem[ELEM_W-1:0];
		sample_re <= re[SAMPLE_BITS-1:0];
		sample_im <= im[SAMPLE_BITS-1:0];
		read_row <= row[ELEM_W-1:0];
		read_col <= col[ELEM_W-1:0];
		do @(posedge clk); while (full);
		if (gap_max > 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(int value);
		wait_drained();
		repeat (SETTLE_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value[NUM_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_count(value);
		n_settings++;
	endtask

	function automatic int rand_sample();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic run_phase(int items);
		int done, len, act, col, r;
		bit pressed;
		done = 0;
		pressed = 0;
		act = sb.in_use;
		while (done < items) begin
			r = $urandom_range(0, 99);
			if (r < 55 && act > 0) begin
				len = ($urandom_range(0, 7) == 0) ? act : $urandom_range(1, (act < 8) ? act : 8);
				for (int e = 0; e < len; e++)
					send(FUNC_SAMPLE, e, rand_sample(), rand_sample(), 0, 0);
				done += len;
			end else if (r < 80) begin
				if (act > 0 && $urandom_range(0, 3) != 0) begin
					col = $urandom_range(0, act - 1);
					send(FUNC_READ, 0, 0, 0, $urandom_range(0, col), col);
				end else
					send(FUNC_READ, 0, 0, 0, $urandom_range(0, 63), $urandom_range(0, 63));
				done++;
			end else if (r < 85) begin
				send(FUNC_CLEAR, 0, 0, 0, 0, 0);
				done++;
			end else if (r < 93) begin
				len = $urandom_range(0, 63);
				send(FUNC_SAMPLE, len, rand_sample(), rand_sample(), 0, 0);
				if (len < act)
					done++;
			end else
				send(FUNC_NONE, $urandom_range(0, 63), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 63), $urandom_range(0, 63));
			if (!pressed && done >= items / 2) begin
				wait_drained();
				pressed = 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		func = FUNC_SAMPLE;
		element = '0;
		sample_re = '0;
		sample_im = '0;
		read_row = '0;
		read_col = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_count(MAX_ELEMENTS);

		// fill the whole slice buffer first, field extremes up front
		send(FUNC_SAMPLE, 0, -32768, -32768, 0, 0);
		send(FUNC_SAMPLE, 1, 32767, 32767, 0, 0);
		send(FUNC_SAMPLE, 2, -32768, 32767, 0, 0);
		send(FUNC_SAMPLE, 3, 32767, -32768, 0, 0);
		for (int e = 4; e < MAX_ELEMENTS; e++)
			send(FUNC_SAMPLE, e, rand_sample(), rand_sample(), 0, 0);
		send(FUNC_READ, 0, 0, 0, 0, 0);
		send(FUNC_READ, 0, 0, 0, 0, 63);
		send(FUNC_READ, 0, 0, 0, 63, 63);
		send(FUNC_READ, 0, 0, 0, 1, 3);
		send(FUNC_READ, 0, 0, 0, 1, 0);
		send(FUNC_READ, 0, 0, 0, 63, 62);
		send(FUNC_NONE, 63, -1, -1, 63, 63);
		// out-of-order element reuses stale slice entries
		send(FUNC_SAMPLE, 5, 1234, -4321, 0, 0);
		send(FUNC_READ, 0, 0, 0, 5, 5);
		send(FUNC_READ, 0, 0, 0, 0, 5);
		send(FUNC_CLEAR, 0, 0, 0, 0, 0);
		send(FUNC_READ, 0, 0, 0, 0, 63);
		send(FUNC_SAMPLE, 0, -32768, -32768, 0, 0);
		send(FUNC_READ, 0, 0, 0, 0, 0);

		gap_max = 6;
		pop_pct = 60;
		run_phase(50);
		write_count(1);
		pop_pct = 25;
		run_phase(30);
		write_count(127);
		gap_max = 0;
		pop_pct = 100;
		run_phase(50);
		write_count(0);
		gap_max = 3;
		pop_pct = 40;
		run_phase(20);
		write_count(17);
		pop_pct = 85;
		run_phase(50);
		write_count($urandom_range(2, 63));
		gap_max = 10;
		pop_pct = 50;
		run_phase(50);
		write_count(MAX_ELEMENTS);
		gap_max = 2;
		run_phase(50);

		wait_drained();
		repeat (100) @(posedge clk);
		$display("Run covered %0d input transfers, %0d visibility reads, %0d register settings",
			n_inputs, n_reads, n_settings);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/cci_pkg.sv
hdl/cci_front.sv
hdl/cci_back.sv
hdl/cross_correlation_integrator.sv
verif/testbench.sv
